/* rtl/plc_pkg.sv */
// Shared request codes, status codes and cell commands for the positional list engine.
package plc_pkg;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_READ   = 3'd4,
        REQ_WRITE  = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Command broadcast to every cell of the row.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_cell_op;

endpackage

/* rtl/positional_list_engine.sv */
// Top level of the positional list engine: request decode, count, result register, cell row.
//
//  channel   dir   fields (low bit up)                         handshake
//  s_axis    in    req_type[2:0] position[10:3] value[42:11]    i_s_tvalid / o_s_tready
//  m_axis    out   read_value[31:0] count[39:32] status[41:40]  o_m_tvalid / i_m_tready
//
// Insert and remove shift all cells in parallel, push and write load one cell, in the cycle
// the beat is accepted; the result beat is registered at that same edge.
// A new beat is taken whenever the result register is empty or being drained.
// Reset clears the entry count and the result valid; entry storage is not cleared.
// A stalled result holds its beat and blocks input until taken.
module positional_list_engine #(
    parameter int CAPACITY   = 128,
    parameter int WORD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [plc_pkg::IN_W-1:0] i_s_tdata,   // req_type, position, value
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [plc_pkg::OUT_W-1:0] o_m_tdata   // read_value, count, status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CW    = (CNT_W > plc_pkg::POS_W) ? CNT_W : plc_pkg::POS_W;

    // Input fields
    logic [plc_pkg::REQ_W-1:0]   w_req_bits;
    logic [plc_pkg::POS_W-1:0]   w_pos;
    logic [plc_pkg::VALUE_W-1:0] w_value;
    logic [WORD_WIDTH-1:0]       w_word;
    logic [CW-1:0]               w_pos_ext;
    logic [CW-1:0]               w_cnt_ext;
    logic                        w_full;
    logic                        w_accept;

    assign w_req_bits = i_s_tdata[2:0];
    assign w_pos      = i_s_tdata[10:3];
    assign w_value    = i_s_tdata[42:11];
    assign w_word     = WORD_WIDTH'(64'($signed(w_value)));
    assign w_pos_ext  = CW'(w_pos);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign w_cnt_ext = CW'(r_cnt);
    assign w_full    = (r_cnt == CNT_W'(CAPACITY));

    // Result register
    logic                           r_out_valid;
    logic [plc_pkg::VALUE_W-1:0]    r_rd;
    logic [plc_pkg::COUNT_W-1:0]    r_cnt_out;
    plc_pkg::t_status               r_status;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Cell row
    logic [WORD_WIDTH-1:0] w_entry [CAPACITY];
    logic [WORD_WIDTH-1:0] w_rd_raw;
    logic [IDX_W-1:0]      w_rd_idx;
    plc_pkg::t_cell_op     w_op;
    plc_pkg::t_cell_op     w_cell_op;
    logic [CW-1:0]         w_idx;
    logic [plc_pkg::VALUE_W-1:0] w_rd;
    plc_pkg::t_status      w_status;

    assign w_rd_idx = w_pos_ext[IDX_W-1:0];
    assign w_rd_raw = w_entry[w_rd_idx];

    always_comb begin
        w_op     = plc_pkg::OP_NONE;
        w_idx    = w_pos_ext;
        n_cnt    = r_cnt;
        w_status = plc_pkg::ST_OK;
        w_rd     = '0;
        case (plc_pkg::t_req'(w_req_bits))
            plc_pkg::REQ_PUSH: begin
                if (w_full) begin
                    w_status = plc_pkg::ST_FULL;
                end else begin
                    w_op  = plc_pkg::OP_LOAD;
                    w_idx = w_cnt_ext;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            plc_pkg::REQ_POP: begin
                if (r_cnt == '0) begin
                    w_status = plc_pkg::ST_EMPTY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            plc_pkg::REQ_INSERT: begin
                // range check wins over the full check
                if (w_pos_ext > w_cnt_ext) begin
                    w_status = plc_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = plc_pkg::ST_FULL;
                end else begin
                    w_op  = plc_pkg::OP_INSERT;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            plc_pkg::REQ_REMOVE: begin
                if (w_pos_ext >= w_cnt_ext) begin
                    w_status = plc_pkg::ST_RANGE;
                end else begin
                    w_op  = plc_pkg::OP_REMOVE;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            plc_pkg::REQ_READ: begin
                if (w_pos_ext >= w_cnt_ext) begin
                    w_status = plc_pkg::ST_RANGE;
                end else begin
                    w_rd = plc_pkg::VALUE_W'(64'($signed(w_rd_raw)));
                end
            end
            plc_pkg::REQ_WRITE: begin
                if (w_pos_ext >= w_cnt_ext) begin
                    w_status = plc_pkg::ST_RANGE;
                end else begin
                    w_op = plc_pkg::OP_LOAD;
                end
            end
            default: begin
                w_status = plc_pkg::ST_OK;
            end
        endcase
    end

    assign w_cell_op = w_accept ? w_op : plc_pkg::OP_NONE;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [WORD_WIDTH-1:0] w_left;
            logic [WORD_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[gi+1];
            end
            plc_cell #(
                .WORD_WIDTH (WORD_WIDTH),
                .CW         (CW),
                .INDEX      (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_cell_op),
                .i_idx   (w_idx),
                .i_word  (w_word),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; hold while the beat is stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd      <= w_rd;
            r_cnt_out <= plc_pkg::COUNT_W'(n_cnt);
            r_status  <= w_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_status, r_cnt_out, r_rd};

endmodule

/* rtl/plc_cell.sv */
// One list slot: holds an entry and trades it with its neighbors on insert and remove.
module plc_cell #(
    parameter int WORD_WIDTH = 32,
    parameter int CW         = 8,
    parameter int INDEX      = 0
) (
    input  logic                      i_clk,
    input  plc_pkg::t_cell_op         i_op,
    input  logic [CW-1:0]             i_idx,
    input  logic [WORD_WIDTH-1:0]     i_word,
    input  logic [WORD_WIDTH-1:0]     i_left,
    input  logic [WORD_WIDTH-1:0]     i_right,
    output logic [WORD_WIDTH-1:0]     o_entry
);

    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

    logic [WORD_WIDTH-1:0] r_entry;
    logic [WORD_WIDTH-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            plc_pkg::OP_LOAD: begin
                if (i_idx == MY_IDX) n_entry = i_word;
            end
            plc_pkg::OP_INSERT: begin
                // take the neighbor below when the gap opens under us
                if (i_idx == MY_IDX) begin
                    n_entry = i_word;
                end else if (MY_IDX > i_idx) begin
                    n_entry = i_left;
                end
            end
            plc_pkg::OP_REMOVE: begin
                if (MY_IDX >= i_idx) n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
